// ===== rtl/gcib_pkg.sv =====
package gcib_pkg;

   // Default sizes of the block
   localparam int BEARING_WIDTH_DEF = 24;
   localparam int CORDIC_STAGES_DEF = 24;

   // Angle width (one turn = 2^32) and CORDIC datapath widths
   localparam int ANGLE_W  = 32;
   localparam int TRIG_W   = 32;
   localparam int ROT_W    = 34;
   localparam int VEC_W    = 35;

   // Start vector of the rotation CORDIC: reciprocal of the infinite-stage gain in Q30
   localparam logic signed [ROT_W-1:0] GAIN_Q30 = 34'sd652032874;

   // Half turn as a binary angle
   localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

   // Arctangent of 2^-i as a binary angle, 2^32 = one turn
   function automatic logic [ANGLE_W-1:0] atan_entry(input int idx);
      logic [ANGLE_W-1:0] r;
      case (idx)
         0:  r = 32'h20000000;
         1:  r = 32'h12E4051E;
         2:  r = 32'h09FB385B;
         3:  r = 32'h051111D4;
         4:  r = 32'h028B0D43;
         5:  r = 32'h0145D7E1;
         6:  r = 32'h00A2F61E;
         7:  r = 32'h00517C55;
         8:  r = 32'h0028BE53;
         9:  r = 32'h00145F2F;
         10: r = 32'h000A2F98;
         11: r = 32'h000517CC;
         12: r = 32'h00028BE6;
         13: r = 32'h000145F3;
         14: r = 32'h0000A2FA;
         15: r = 32'h0000517D;
         16: r = 32'h000028BE;
         17: r = 32'h0000145F;
         18: r = 32'h00000A30;
         19: r = 32'h00000518;
         20: r = 32'h0000028C;
         21: r = 32'h00000146;
         22: r = 32'h000000A3;
         23: r = 32'h00000051;
         24: r = 32'h00000029;
         25: r = 32'h00000014;
         26: r = 32'h0000000A;
         27: r = 32'h00000005;
         28: r = 32'h00000003;
         29: r = 32'h00000001;
         30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/gcib_sincos.sv =====
module gcib_sincos #(
   parameter int CORDIC_STAGES = gcib_pkg::CORDIC_STAGES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [2:0][gcib_pkg::ANGLE_W-1:0] angle,
   output logic out_valid,
   output logic signed [gcib_pkg::TRIG_W-1:0] sin_val [3],
   output logic signed [gcib_pkg::TRIG_W-1:0] cos_val [3]
);
   import gcib_pkg::*;

   logic                    v_ff    [0:CORDIC_STAGES];
   logic                    flip_ff [0:CORDIC_STAGES][3];
   logic signed [ROT_W-1:0] x_ff    [0:CORDIC_STAGES][3];
   logic signed [ROT_W-1:0] y_ff    [0:CORDIC_STAGES][3];
   logic signed [ROT_W-1:0] z_ff    [0:CORDIC_STAGES][3];
   logic                    ov_ff;
   logic signed [TRIG_W-1:0] sin_ff [3];
   logic signed [TRIG_W-1:0] cos_ff [3];
   logic                    flip_in [3];
   logic [ANGLE_W-1:0]      red_in  [3];

   // Fold the left half-plane onto the right by a half turn
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         flip_in[l] = angle[l][ANGLE_W-1] ^ angle[l][ANGLE_W-2];
         red_in[l]  = {angle[l][ANGLE_W-1] ^ flip_in[l], angle[l][ANGLE_W-2:0]};
      end
   end

   // Load the start vector
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         for (int l = 0; l < 3; l++) begin
            flip_ff[0][l] <= flip_in[l];
            x_ff[0][l]    <= GAIN_Q30;
            y_ff[0][l]    <= '0;
            z_ff[0][l]    <= ROT_W'(signed'(red_in[l]));
         end
      end
   end

   // Rotate one micro-angle per stage
   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_rot
      localparam logic signed [ROT_W-1:0] TAB = ROT_W'(atan_entry(s));
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (en) begin
            v_ff[s+1] <= v_ff[s];
         end
         if (en) begin
            for (int l = 0; l < 3; l++) begin
               flip_ff[s+1][l] <= flip_ff[s][l];
               if (!z_ff[s][l][ROT_W-1]) begin
                  x_ff[s+1][l] <= x_ff[s][l] - (y_ff[s][l] >>> s);
                  y_ff[s+1][l] <= y_ff[s][l] + (x_ff[s][l] >>> s);
                  z_ff[s+1][l] <= z_ff[s][l] - TAB;
               end else begin
                  x_ff[s+1][l] <= x_ff[s][l] + (y_ff[s][l] >>> s);
                  y_ff[s+1][l] <= y_ff[s][l] - (x_ff[s][l] >>> s);
                  z_ff[s+1][l] <= z_ff[s][l] + TAB;
               end
            end
         end
      end
   end

   // Undo the fold and register the results
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= v_ff[CORDIC_STAGES];
      end
      if (en) begin
         for (int l = 0; l < 3; l++) begin
            if (flip_ff[CORDIC_STAGES][l]) begin
               sin_ff[l] <= TRIG_W'(-y_ff[CORDIC_STAGES][l]);
               cos_ff[l] <= TRIG_W'(-x_ff[CORDIC_STAGES][l]);
            end else begin
               sin_ff[l] <= TRIG_W'(y_ff[CORDIC_STAGES][l]);
               cos_ff[l] <= TRIG_W'(x_ff[CORDIC_STAGES][l]);
            end
         end
      end
   end

   assign out_valid = ov_ff;
   assign sin_val   = sin_ff;
   assign cos_val   = cos_ff;

endmodule

// ===== rtl/gcib_products.sv =====
module gcib_products (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic signed [gcib_pkg::TRIG_W-1:0] sin_a,
   input  logic signed [gcib_pkg::TRIG_W-1:0] cos_a,
   input  logic signed [gcib_pkg::TRIG_W-1:0] sin_b,
   input  logic signed [gcib_pkg::TRIG_W-1:0] cos_b,
   input  logic signed [gcib_pkg::TRIG_W-1:0] sin_d,
   input  logic signed [gcib_pkg::TRIG_W-1:0] cos_d,
   output logic out_valid,
   output logic signed [gcib_pkg::ROT_W-1:0] vec_x,
   output logic signed [gcib_pkg::ROT_W-1:0] vec_y
);
   import gcib_pkg::*;

   localparam int PW = 2 * TRIG_W;
   localparam int MW = TRIG_W + ROT_W;

   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [PW-1:0]     py_ff, pt_ff, pab_ff;
   logic signed [TRIG_W-1:0] sa_ff;
   logic signed [ROT_W-1:0]  y2_ff;
   logic signed [PW-1:0]     pab2_ff;
   logic signed [MW-1:0]     m_ff;
   logic signed [ROT_W-1:0]  t_in;
   logic signed [MW-1:0]     diff_in;
   logic signed [ROT_W-1:0]  x3_ff, y3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // First products
   always_ff @(posedge clock) begin
      if (en) begin
         py_ff  <= PW'(sin_d) * PW'(cos_b);
         pt_ff  <= PW'(cos_b) * PW'(cos_d);
         pab_ff <= PW'(cos_a) * PW'(sin_b);
         sa_ff  <= sin_a;
      end
   end

   // Scale back to Q30 and form sin(lat_a) * t
   assign t_in = ROT_W'(pt_ff >>> 30);

   always_ff @(posedge clock) begin
      if (en) begin
         y2_ff   <= ROT_W'(py_ff >>> 30);
         pab2_ff <= pab_ff;
         m_ff    <= MW'(sa_ff) * MW'(t_in);
      end
   end

   // Subtract and scale for x
   assign diff_in = MW'(pab2_ff) - m_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         x3_ff <= ROT_W'(diff_in >>> 30);
         y3_ff <= y2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign vec_x     = x3_ff;
   assign vec_y     = y3_ff;

endmodule

// ===== rtl/gcib_atan2.sv =====
module gcib_atan2 #(
   parameter int BEARING_WIDTH = gcib_pkg::BEARING_WIDTH_DEF,
   parameter int CORDIC_STAGES = gcib_pkg::CORDIC_STAGES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic signed [gcib_pkg::ROT_W-1:0] vec_x,
   input  logic signed [gcib_pkg::ROT_W-1:0] vec_y,
   output logic out_valid,
   output logic [BEARING_WIDTH-1:0] bearing
);
   import gcib_pkg::*;

   localparam int SH = ANGLE_W - BEARING_WIDTH;
   localparam logic [ANGLE_W:0] HALF = (SH == 0) ? '0 : ((ANGLE_W+1)'(1) << (SH - 1));

   logic                    v_ff    [0:CORDIC_STAGES];
   logic                    zero_ff [0:CORDIC_STAGES];
   logic signed [VEC_W-1:0] x_ff    [0:CORDIC_STAGES];
   logic signed [VEC_W-1:0] y_ff    [0:CORDIC_STAGES];
   logic [ANGLE_W-1:0]      z_ff    [0:CORDIC_STAGES];
   logic                    ov_ff;
   logic [BEARING_WIDTH-1:0] b_ff;
   logic signed [VEC_W-1:0] xe_in, ye_in;
   logic [ANGLE_W:0]        sum_in;
   logic [ANGLE_W:0]        shr_in;

   assign xe_in = VEC_W'(vec_x);
   assign ye_in = VEC_W'(vec_y);

   // Mirror into the right half-plane, flag the null vector
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         zero_ff[0] <= (vec_x == '0) && (vec_y == '0);
         if (vec_x[ROT_W-1]) begin
            x_ff[0] <= -xe_in;
            y_ff[0] <= -ye_in;
            z_ff[0] <= HALF_TURN;
         end else begin
            x_ff[0] <= xe_in;
            y_ff[0] <= ye_in;
            z_ff[0] <= '0;
         end
      end
   end

   // Drive y toward zero, one micro-angle per stage
   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_vec
      localparam logic [ANGLE_W-1:0] TAB = atan_entry(s);
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (en) begin
            v_ff[s+1] <= v_ff[s];
         end
         if (en) begin
            zero_ff[s+1] <= zero_ff[s];
            if (!y_ff[s][VEC_W-1] && (y_ff[s] != '0)) begin
               x_ff[s+1] <= x_ff[s] + (y_ff[s] >>> s);
               y_ff[s+1] <= y_ff[s] - (x_ff[s] >>> s);
               z_ff[s+1] <= z_ff[s] + TAB;
            end else begin
               x_ff[s+1] <= x_ff[s] - (y_ff[s] >>> s);
               y_ff[s+1] <= y_ff[s] + (x_ff[s] >>> s);
               z_ff[s+1] <= z_ff[s] - TAB;
            end
         end
      end
   end

   // Round half up to the output width, wrapping at a full turn
   assign sum_in = {1'b0, z_ff[CORDIC_STAGES]} + HALF;
   assign shr_in = sum_in >> SH;

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= v_ff[CORDIC_STAGES];
      end
      if (en) begin
         if (zero_ff[CORDIC_STAGES]) begin
            b_ff <= '0;
         end else begin
            b_ff <= shr_in[BEARING_WIDTH-1:0];
         end
      end
   end

   assign out_valid = ov_ff;
   assign bearing   = b_ff;

endmodule

// ===== rtl/great_circle_initial_bearing_top.sv =====
// Initial great-circle bearing from point A to point B.
// Request channel: req_valid with req_lat_a, req_lon_a, req_lat_b, req_lon_b
// (signed binary angles, 2^31 = 180 degrees); a transaction is taken at a
// clock edge with req_valid high and req_stall low.
// Response channel: rsp_valid with rsp_bearing (2^BEARING_WIDTH = one turn,
// clockwise from north); a transaction completes with rsp_valid high and
// rsp_stall low. Exactly one response per request, in order.
// Throughput: one transaction per cycle while req_stall is low. The path runs
// through the sin/cos CORDIC, three multiply stages, the atan2 CORDIC and rounding;
// the two unrolled CORDIC pipelines make up most of it.
// Reset (synchronous, active high) empties the pipeline and the output
// registers; no state carries between transactions.
// When the receiver stalls, a finished result is held on the response port
// and the next one parks in a spare register; the pipeline and req_stall
// freeze only while that spare register is full.
module great_circle_initial_bearing_top #(
   parameter int BEARING_WIDTH = gcib_pkg::BEARING_WIDTH_DEF,
   parameter int CORDIC_STAGES = gcib_pkg::CORDIC_STAGES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [31:0] req_lat_a,
   input  logic signed [31:0] req_lon_a,
   input  logic signed [31:0] req_lat_b,
   input  logic signed [31:0] req_lon_b,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [BEARING_WIDTH-1:0] rsp_bearing
);
   import gcib_pkg::*;

   logic                     en;
   logic [2:0][ANGLE_W-1:0]  angles;
   logic                     sc_valid;
   logic signed [TRIG_W-1:0] sin_v [3];
   logic signed [TRIG_W-1:0] cos_v [3];
   logic                     pr_valid;
   logic signed [ROT_W-1:0]  vx, vy;
   logic                     tail_valid;
   logic [BEARING_WIDTH-1:0] tail_bearing;
   logic                     rsp_valid_ff, skid_valid_ff;
   logic [BEARING_WIDTH-1:0] rsp_bearing_ff, skid_bearing_ff;
   logic                     out_free;

   // Advance the pipeline while the spare register is empty
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   assign angles[0] = req_lat_a;
   assign angles[1] = req_lat_b;
   assign angles[2] = req_lon_b - req_lon_a;

   gcib_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sincos (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .angle    (angles),
      .out_valid(sc_valid),
      .sin_val  (sin_v),
      .cos_val  (cos_v)
   );

   gcib_products u_products (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (sc_valid),
      .sin_a    (sin_v[0]),
      .cos_a    (cos_v[0]),
      .sin_b    (sin_v[1]),
      .cos_b    (cos_v[1]),
      .sin_d    (sin_v[2]),
      .cos_d    (cos_v[2]),
      .out_valid(pr_valid),
      .vec_x    (vx),
      .vec_y    (vy)
   );

   gcib_atan2 #(
      .BEARING_WIDTH(BEARING_WIDTH),
      .CORDIC_STAGES(CORDIC_STAGES)
   ) u_atan2 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (pr_valid),
      .vec_x    (vx),
      .vec_y    (vy),
      .out_valid(tail_valid),
      .bearing  (tail_bearing)
   );

   // Output register and spare register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (!rsp_stall) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (tail_valid && !out_free) begin
            skid_valid_ff <= 1'b1;
         end
         if (out_free) begin
            rsp_valid_ff <= skid_valid_ff || tail_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_bearing_ff <= skid_bearing_ff;
         end else begin
            rsp_bearing_ff <= tail_bearing;
         end
      end
      if (!skid_valid_ff && tail_valid && !out_free) begin
         skid_bearing_ff <= tail_bearing;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_bearing = rsp_bearing_ff;

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("spare register full with empty output register");
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> (rsp_valid_ff && !skid_valid_ff))
      else $error("spare register did not move to the output");
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_stall) |=> (skid_valid_ff && $stable(skid_bearing_ff)))
      else $error("spare register lost its transaction");
`endif

endmodule

// ===== tb/sv/great_circle_initial_bearing_top_tb.sv =====
module great_circle_initial_bearing_top_tb;
   import gcib_pkg::*;

   localparam int BW         = BEARING_WIDTH_DEF;
   localparam int NSTAGE     = CORDIC_STAGES_DEF;
   localparam int LATENCY    = 2 * NSTAGE + 7;
   localparam int WDOG_LIMIT = 20000;
   localparam int N_RANDOM   = 1400;

   typedef longint signed s64_t;

   // Bearing predictor and store of expected bearings
   class bearing_scoreboard;
      logic [BW-1:0] pending_bearings[$];
      int            n_fail;
      int            n_checked;

      function new();
         n_fail    = 0;
         n_checked = 0;
      endfunction

      static function s64_t floor_shift(s64_t v, int s);
         return v >>> s;
      endfunction

      static function void rotate_sin_cos(logic [31:0] ang, output s64_t s, output s64_t c);
         logic [1:0] quad;
         bit         flip;
         s64_t       x, y, z, dx, dy;
         quad = ang[31:30];
         flip = (quad == 2'd1 || quad == 2'd2);
         x = GAIN_Q30;
         y = 0;
         if (flip) ang = ang - HALF_TURN;
         z = s64_t'($signed(ang));
         for (int i = 0; i < NSTAGE && i < 32; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
               x = x - dx; y = y + dy; z = z - s64_t'(atan_entry(i));
            end else begin
               x = x + dx; y = y - dy; z = z + s64_t'(atan_entry(i));
            end
         end
         if (flip) begin
            x = -x; y = -y;
         end
         s = y;
         c = x;
      endfunction

      static function logic [31:0] vector_angle(s64_t y, s64_t x);
         logic [31:0] z;
         s64_t        dx, dy;
         z = '0;
         if (x < 0) begin
            x = -x; y = -y; z = HALF_TURN;
         end
         for (int i = 0; i < NSTAGE && i < 32; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0) begin
               x = x + dx; y = y - dy; z = z + atan_entry(i);
            end else begin
               x = x - dx; y = y + dy; z = z - atan_entry(i);
            end
         end
         return z;
      endfunction

      static function logic [BW-1:0] initial_bearing(logic [31:0] lat_a, logic [31:0] lon_a,
                                                     logic [31:0] lat_b, logic [31:0] lon_b);
         s64_t        sa, ca, sb, cb, sd, cd, x, y, t;
         logic [31:0] z;
         logic [32:0] rounded;
         rotate_sin_cos(lat_a, sa, ca);
         rotate_sin_cos(lat_b, sb, cb);
         rotate_sin_cos(lon_b - lon_a, sd, cd);
         y = floor_shift(sd * cb, 30);
         t = floor_shift(cb * cd, 30);
         x = floor_shift(ca * sb - sa * t, 30);
         // both components zero: bearing is north
         if (x == 0 && y == 0) return '0;
         z = vector_angle(y, x);
         if (BW == 32) return z;
         rounded = {1'b0, z} + (33'd1 << (32 - BW - 1));
         return rounded[32 - BW +: BW];
      endfunction

      function void note_request(logic [31:0] la, logic [31:0] oa, logic [31:0] lb,
                                 logic [31:0] ob);
         pending_bearings.push_back(initial_bearing(la, oa, lb, ob));
      endfunction

      function void check_response(logic [BW-1:0] got);
         logic [BW-1:0] want;
         if (pending_bearings.size() == 0) begin
            $display("%0t: unexpected response, bearing %h", $time, got);
            n_fail++;
            return;
         end
         want = pending_bearings.pop_front();
         n_checked++;
         if (got !== want) begin
            $display("%0t: bearing mismatch, expected %h, actual %h", $time, want, got);
            n_fail++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic signed [31:0] req_lat_a, req_lon_a, req_lat_b, req_lon_b;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [BW-1:0]     rsp_bearing;

   bearing_scoreboard sb;
   int  send_idle_pct;
   int  recv_stall_pct;
   int  quiet_cycles;
   int  n_sent;
   bit  all_sent;

   great_circle_initial_bearing_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_lat_a   (req_lat_a),
      .req_lon_a   (req_lon_a),
      .req_lat_b   (req_lat_b),
      .req_lon_b   (req_lon_b),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_bearing (rsp_bearing)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver: random stall, check each completed transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_bearing);
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Watchdog: count cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Offer one transaction, idle first at random, hold until taken
   task automatic send_points(logic [31:0] la, logic [31:0] oa, logic [31:0] lb,
                              logic [31:0] ob);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_lat_a <= la;
      req_lon_a <= oa;
      req_lat_b <= lb;
      req_lon_b <= ob;
      do @(posedge clock); while (req_stall);
      sb.note_request(la, oa, lb, ob);
      n_sent++;
   endtask

   function automatic logic [31:0] pick_lat();
      case ($urandom_range(9))
         0: return 32'h4000_0000;
         1: return 32'hC000_0000;
         2: return $urandom();
         3: return 32'(int'($urandom_range(16)) - 8);
         default: return 32'($signed(33'($urandom_range(32'h8000_0000))) - 33'sh4000_0000);
      endcase
   endfunction

   function automatic logic [31:0] pick_lon();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(int'($urandom_range(16)) - 8);
         default: return $urandom();
      endcase
   endfunction

   task automatic random_batch(int n, int idle, int stall);
      logic [31:0] la, oa, lb, ob;
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < n; i++) begin
         la = pick_lat();
         oa = pick_lon();
         lb = pick_lat();
         ob = pick_lon();
         // sometimes coincident or antipodal points
         case ($urandom_range(15))
            0: begin lb = la; ob = oa; end
            1: begin lb = -la; ob = oa + HALF_TURN; end
            default: ;
         endcase
         send_points(la, oa, lb, ob);
      end
   endtask

   initial begin
      sb             = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_lat_a      = '0;
      req_lon_a      = '0;
      req_lat_b      = '0;
      req_lon_b      = '0;
      rsp_stall      = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      quiet_cycles   = 0;
      n_sent         = 0;
      all_sent       = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: coincident, antipodal, poles, extremes, cardinal directions
      send_points(32'h0, 32'h0, 32'h0, 32'h0);
      send_points(32'h1000_0000, 32'h2000_0000, 32'hF000_0000, 32'hA000_0000);
      send_points(32'h4000_0000, 32'h0, 32'h0, 32'h1234_5678);
      send_points(32'hC000_0000, 32'h0, 32'h0, 32'h1234_5678);
      send_points(32'h0, 32'h0, 32'h4000_0000, 32'h0);
      send_points(32'h0, 32'h0, 32'hC000_0000, 32'h0);
      send_points(32'h0, 32'h0, 32'h0, 32'h0100_0000);
      send_points(32'h0, 32'h0, 32'h0, 32'hFF00_0000);
      send_points(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
      send_points(32'h0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
      send_points(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_points(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h5555_5555);
      send_points(32'h8000_0000, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h0);
      send_points(32'h4000_0000, 32'h1, 32'hC000_0000, 32'h0);
      send_points(32'h0, 32'h0, 32'h1, 32'h0);
      send_points(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
      send_points(32'h2000_0000, 32'h0, 32'h2000_0000, 32'h8000_0000);

      // Random phases with different idling patterns
      random_batch(350, 0, 0);
      random_batch(350, 79, 0);
      random_batch(350, 0, 79);
      random_batch(350, 37, 37);
      // Drop the request once the last transaction is taken
      req_valid      <= 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      all_sent = 1;

      while (sb.pending_bearings.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("Sent %0d point pairs across four idling phases; %0d bearings checked.",
               n_sent, sb.n_checked);
      if (sb.n_fail == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
